[hdl/assert_macros.svh]
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, checked outside reset.
`define PHD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the following cycle, checked outside reset.
`define PHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/phd_pkg.sv]
// Types and constants of the packet header deframer.
`default_nettype none

package phd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned LenW       = 16;
  localparam int unsigned MagicW     = 32;
  localparam int unsigned CountW     = 17;
  localparam int unsigned SizeW      = CountW + 1;
  localparam int unsigned CfgIndexW  = 8;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Byte positions within the header.
  localparam int unsigned MagicBytes  = 4;
  localparam int unsigned LenPos      = 4;
  localparam int unsigned CodePos     = 6;
  localparam int unsigned CustomAPos  = 8;
  localparam int unsigned CustomBPos  = 10;
  localparam int unsigned PrefixBytes = 12;
  localparam int unsigned LenOverhead = 6;

  // Result queue; the depth must be a power of two so the pointers wrap.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [CfgIndexW-1:0] {
    CfgMagicWord   = 8'd0,
    CfgIgnoreLen   = 8'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    CauseNone     = 2'd0,
    CauseMagic    = 2'd1,
    CauseShort    = 2'd2,
    CauseLength   = 2'd3
  } cause_e;

  typedef enum logic {
    KindPayload = 1'b0,
    KindVerdict = 1'b1
  } kind_e;

  typedef struct packed {
    logic [MagicW-1:0] magic_word;
    logic              ignore_length_mismatch;
  } cfg_t;

  typedef struct packed {
    kind_e            item_kind;
    logic [ByteW-1:0] payload_value;
    logic             run_end;
    logic             accepted;
    cause_e           reject_cause;
    logic [LenW-1:0]  length_value;
    logic [ByteW-1:0] code_first;
    logic [ByteW-1:0] code_second;
    logic [ByteW-1:0] custom_a;
    logic [ByteW-1:0] custom_b;
  } result_t;

  // Up to two results produced by one input beat, in output order.
  typedef struct packed {
    logic [1:0] n;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

[hdl/phd_if.sv]
// Channel interfaces of the packet header deframer: input bytes, results, configuration.
`default_nettype none

interface phd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface phd_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_value;
  logic        run_end;
  logic        accepted;
  logic [1:0]  reject_cause;
  logic [15:0] length_value;
  logic [7:0]  code_first;
  logic [7:0]  code_second;
  logic [7:0]  custom_a;
  logic [7:0]  custom_b;

  modport source (
    output valid, output item_kind, output payload_value, output run_end,
    output accepted, output reject_cause, output length_value, output code_first,
    output code_second, output custom_a, output custom_b, input ready
  );
  modport sink (
    input valid, input item_kind, input payload_value, input run_end,
    input accepted, input reject_cause, input length_value, input code_first,
    input code_second, input custom_a, input custom_b, output ready
  );
endinterface

interface phd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/phd_cfg_regs.sv]
// Configuration registers of the deframer: magic word and length-check override.
`default_nettype none

module phd_cfg_regs (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  phd_cfg_if.sink    cfg_i,
  output phd_pkg::cfg_t cfg_o
);
  import phd_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      // Writes to indexes beyond the register list are dropped.
      if (cfg_i.index == CfgMagicWord) begin
        cfg_d.magic_word = cfg_i.data[MagicW-1:0];
      end else if (cfg_i.index == CfgIgnoreLen) begin
        cfg_d.ignore_length_mismatch = cfg_i.data[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/phd_core.sv]
// Per-byte header parsing, payload pass-through and verdict generation.
`default_nettype none
`include "assert_macros.svh"

module phd_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire phd_pkg::cfg_t     cfg_i,
  input  wire logic              beat_valid_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              final_byte_i,
  output phd_pkg::push_t         push_o
);
  import phd_pkg::*;

  logic [CountW-1:0] byte_count_q, byte_count_d;
  logic              magic_ok_q, magic_ok_d;
  logic [LenW-1:0]   length_q, length_d;
  logic [LenW-1:0]   code_q, code_d;
  logic [ByteW-1:0]  custom_a_q, custom_a_d;
  logic [ByteW-1:0]  custom_b_q, custom_b_d;

  logic [CountW-1:0] pos;
  logic [ByteW-1:0]  magic_byte;
  logic              in_magic;
  logic              magic_ok_now;
  logic [LenW-1:0]   length_now;
  logic [LenW-1:0]   code_now;
  logic [ByteW-1:0]  custom_a_now;
  logic [ByteW-1:0]  custom_b_now;
  logic [SizeW-1:0]  size;
  logic [SizeW-1:0]  expected_size;
  logic              payload_hit;
  cause_e            cause;
  result_t           payload_res;
  result_t           verdict_res;

  assign pos        = byte_count_q;
  assign in_magic   = pos < CountW'(MagicBytes);
  assign magic_byte = cfg_i.magic_word[{pos[1:0], 3'b000} +: ByteW];

  // Header fields as they stand once the current byte has been stored.
  always_comb begin
    magic_ok_now = magic_ok_q;
    length_now   = length_q;
    code_now     = code_q;
    custom_a_now = custom_a_q;
    custom_b_now = custom_b_q;
    if (in_magic) begin
      if (magic_byte != data_byte_i) begin
        magic_ok_now = 1'b0;
      end
    end else if (pos == CountW'(LenPos)) begin
      length_now[7:0] = data_byte_i;
    end else if (pos == CountW'(LenPos + 1)) begin
      length_now[15:8] = data_byte_i;
    end else if (pos == CountW'(CodePos)) begin
      code_now[7:0] = data_byte_i;
    end else if (pos == CountW'(CodePos + 1)) begin
      code_now[15:8] = data_byte_i;
    end else if (pos == CountW'(CustomAPos)) begin
      custom_a_now = data_byte_i;
    end else if (pos == CountW'(CustomBPos)) begin
      custom_b_now = data_byte_i;
    end
  end

  assign size          = {1'b0, pos} + SizeW'(1);
  assign expected_size = {{(SizeW-LenW){1'b0}}, length_now} + SizeW'(LenOverhead);
  assign payload_hit   = (pos >= CountW'(PrefixBytes)) && magic_ok_now;

  always_comb begin
    priority if (!magic_ok_now) begin
      cause = CauseMagic;
    end else if (size < SizeW'(PrefixBytes)) begin
      cause = CauseShort;
    end else if (size != expected_size && !cfg_i.ignore_length_mismatch) begin
      cause = CauseLength;
    end else begin
      cause = CauseNone;
    end
  end

  always_comb begin
    payload_res               = '0;
    payload_res.item_kind     = KindPayload;
    payload_res.payload_value = data_byte_i;
    payload_res.run_end       = !final_byte_i;

    verdict_res               = '0;
    verdict_res.item_kind     = KindVerdict;
    verdict_res.run_end       = 1'b1;
    verdict_res.accepted      = (cause == CauseNone);
    verdict_res.reject_cause  = cause;
    verdict_res.length_value  = length_now;
    verdict_res.code_first    = code_now[7:0];
    verdict_res.code_second   = code_now[15:8];
    verdict_res.custom_a      = custom_a_now;
    verdict_res.custom_b      = custom_b_now;
  end

  // When only a verdict is due it takes the first slot.
  always_comb begin
    push_o.first  = payload_hit ? payload_res : verdict_res;
    push_o.second = verdict_res;
    push_o.n      = beat_valid_i ? ({1'b0, payload_hit} + {1'b0, final_byte_i}) : 2'd0;
  end

  always_comb begin
    byte_count_d = byte_count_q;
    magic_ok_d   = magic_ok_q;
    length_d     = length_q;
    code_d       = code_q;
    custom_a_d   = custom_a_q;
    custom_b_d   = custom_b_q;
    if (beat_valid_i) begin
      if (final_byte_i) begin
        // The packet is over: everything returns to its reset value.
        byte_count_d = '0;
        magic_ok_d   = 1'b1;
        length_d     = '0;
        code_d       = '0;
        custom_a_d   = '0;
        custom_b_d   = '0;
      end else begin
        if (pos != CountMax) begin
          byte_count_d = pos + CountW'(1);
        end
        magic_ok_d = magic_ok_now;
        length_d   = length_now;
        code_d     = code_now;
        custom_a_d = custom_a_now;
        custom_b_d = custom_b_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      magic_ok_q   <= 1'b1;
      length_q     <= '0;
      code_q       <= '0;
      custom_a_q   <= '0;
      custom_b_q   <= '0;
    end else begin
      byte_count_q <= byte_count_d;
      magic_ok_q   <= magic_ok_d;
      length_q     <= length_d;
      code_q       <= code_d;
      custom_a_q   <= custom_a_d;
      custom_b_q   <= custom_b_d;
    end
  end

  `PHD_ASSERT_NEXT(a_clear_after_final, beat_valid_i && final_byte_i,
    byte_count_q == '0 && magic_ok_q, "packet state not cleared after final beat")
  `PHD_ASSERT_IMPL(a_magic_fail_in_header, $fell(magic_ok_q),
    $past(byte_count_q) < CountW'(MagicBytes), "magic flag dropped outside magic bytes")
  `PHD_ASSERT_IMPL(a_two_results_on_final, push_o.n == 2'd2,
    final_byte_i && push_o.first.item_kind == KindPayload, "two results without final payload")

endmodule

`default_nettype wire

[hdl/phd_result_fifo.sv]
// Result queue that takes up to two results per cycle and hands out one per beat.
`default_nettype none
`include "assert_macros.svh"

module phd_result_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire phd_pkg::push_t   push_i,
  output logic                  space_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output phd_pkg::result_t      head_o
);
  import phd_pkg::*;

  result_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   count_q, count_d;
  logic                  pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign head_o  = mem_q[rd_ptr_q];
  // Room for the two results a single beat may bring.
  assign space_o = count_q <= FifoCntW'(FifoDepth - 2);

  assign wr_ptr_d = wr_ptr_q + FifoPtrW'(push_i.n);
  assign rd_ptr_d = rd_ptr_q + FifoPtrW'(pop);
  assign count_d  = count_q + {{(FifoCntW-2){1'b0}}, push_i.n}
                    - {{(FifoCntW-1){1'b0}}, pop};

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_ptr_q + FifoPtrW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `PHD_ASSERT_IMPL(a_no_overflow, push_i.n != 2'd0,
    count_q <= FifoCntW'(FifoDepth) - FifoCntW'(push_i.n), "result queue overflow")
  `PHD_ASSERT_NEXT(a_pop_only_drains, pop && push_i.n == 2'd0,
    count_q == $past(count_q) - FifoCntW'(1), "queue count wrong after pop")

endmodule

`default_nettype wire

[hdl/packet_header_deframer.sv]
// Top level of the length-prefixed packet header deframer.
//
// One packet byte is taken per input beat, at a sustained rate of one beat per cycle.
// Header bytes produce no result unless final; a payload byte produces one result when
// the magic word has matched, and the final beat produces a verdict, after its own
// payload result when it carries one. Results are registered into a four-entry result
// queue and leave it one per output beat; the input is ready while
// that queue holds at most two results. With the output always ready the queue never
// holds more than two, so only back-pressure on the output can hold the input back.
// Downstream must discard the streamed payload of a packet whose verdict rejects it.
`default_nettype none

module packet_header_deframer (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  phd_cfg_if.sink     cfg_i,
  phd_in_if.sink      in_i,
  phd_out_if.source   out_o
);
  import phd_pkg::*;

  cfg_t    cfg;
  push_t   push;
  result_t head;
  logic    space;
  logic    in_fire;

  assign in_i.ready = space;
  assign in_fire    = in_i.valid && space;

  phd_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  phd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .beat_valid_i (in_fire),
    .data_byte_i  (in_i.data_byte),
    .final_byte_i (in_i.final_byte),
    .push_o       (push)
  );

  phd_result_fifo u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .head_o  (head)
  );

  assign out_o.item_kind     = head.item_kind;
  assign out_o.payload_value = head.payload_value;
  assign out_o.run_end       = head.run_end;
  assign out_o.accepted      = head.accepted;
  assign out_o.reject_cause  = head.reject_cause;
  assign out_o.length_value  = head.length_value;
  assign out_o.code_first    = head.code_first;
  assign out_o.code_second   = head.code_second;
  assign out_o.custom_a      = head.custom_a;
  assign out_o.custom_b      = head.custom_b;

endmodule

`default_nettype wire

[tb/sv/packet_header_deframer_tb.sv]
// Self-checking testbench of the packet header deframer: directed packets, then random traffic.
`default_nettype none

module packet_header_deframer_tb;
  import phd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [31:0] magic;
    logic        ignore_len;
    int unsigned size;
    logic [31:0] sent_magic;
    logic [15:0] len_field;
    bit          typed;
    cause_e      cause;
  } packet_case_t;

  typedef struct {
    bit     typed;
    cause_e cause;
  } verdict_note_t;

  logic clk_i;
  logic rst_ni;

  phd_cfg_if cfg_ch ();
  phd_in_if  in_ch ();
  phd_out_if out_ch ();

  packet_header_deframer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Register copy and packet state of the predictor.
  logic [31:0]       cfg_magic;
  logic              cfg_ignore;
  logic [CountW-1:0] byte_pos;
  logic              magic_good;
  logic [15:0]       len_field;
  logic [15:0]       code_field;
  logic [7:0]        custom_a_field;
  logic [7:0]        custom_b_field;

  result_t       expected_results[$];
  verdict_note_t verdict_notes[$];
  bit            failed;
  bit            gaps_allowed;
  bit            stalls_on;
  int unsigned   ready_hold;

  // Rows with a typed cause are also checked against the table, not only the predictor.
  packet_case_t directed_cases [13] = '{
    '{32'h0000_0000, 1'b0, 12, 32'h0000_0000, 16'd6,      1'b1, CauseNone},
    '{32'h0000_0000, 1'b0, 1,  32'h0000_0000, 16'd0,      1'b1, CauseShort},
    '{32'h0000_0000, 1'b0, 3,  32'h0000_0100, 16'd0,      1'b1, CauseMagic},
    '{32'h0000_0000, 1'b0, 11, 32'h0000_0000, 16'd5,      1'b1, CauseShort},
    '{32'hFFFF_FFFF, 1'b0, 18, 32'hFFFF_FFFF, 16'd12,     1'b1, CauseNone},
    '{32'hFFFF_FFFF, 1'b0, 18, 32'hFFFF_FFFF, 16'hFFFF,   1'b1, CauseLength},
    '{32'hFFFF_FFFF, 1'b0, 20, 32'hFFFF_FFFE, 16'd14,     1'b1, CauseMagic},
    '{32'hFFFF_FFFF, 1'b0, 5,  32'h7FFF_FFFF, 16'd0,      1'b1, CauseMagic},
    '{32'hA5C3_1E69, 1'b1, 30, 32'hA5C3_1E69, 16'd0,      1'b1, CauseNone},
    '{32'hA5C3_1E69, 1'b1, 8,  32'hA5C3_1E69, 16'd2,      1'b1, CauseShort},
    '{32'hA5C3_1E69, 1'b1, 12, 32'hA5C3_1E69, 16'd6,      1'b0, CauseNone},
    '{32'h0000_0000, 1'b0, 13, 32'h0000_0000, 16'd7,      1'b0, CauseNone},
    '{32'h0000_0000, 1'b0, 12, 32'h0000_0000, 16'd0,      1'b1, CauseLength}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void clear_packet();
    byte_pos       = '0;
    magic_good     = 1'b1;
    len_field      = '0;
    code_field     = '0;
    custom_a_field = '0;
    custom_b_field = '0;
  endfunction

  // Works out the results that one accepted input beat causes.
  function automatic void predict_beat(input logic [7:0] data, input logic fin);
    logic [CountW-1:0] pos;
    logic [SizeW-1:0]  size;
    result_t           r;
    cause_e            cause;
    pos = byte_pos;
    if (pos < MagicBytes) begin
      if (cfg_magic[8*pos +: 8] != data) magic_good = 1'b0;
    end else if (pos == LenPos) begin
      len_field[7:0] = data;
    end else if (pos == LenPos + 1) begin
      len_field[15:8] = data;
    end else if (pos == CodePos) begin
      code_field[7:0] = data;
    end else if (pos == CodePos + 1) begin
      code_field[15:8] = data;
    end else if (pos == CustomAPos) begin
      custom_a_field = data;
    end else if (pos == CustomBPos) begin
      custom_b_field = data;
    end
    if (pos != CountMax) byte_pos = pos + 1'b1;

    if (pos >= PrefixBytes && magic_good) begin
      r = '0;
      r.item_kind     = KindPayload;
      r.payload_value = data;
      r.run_end       = !fin;
      expected_results = {expected_results, r};
    end

    if (fin) begin
      size = {1'b0, pos} + 1'b1;
      if (!magic_good) cause = CauseMagic;
      else if (size < PrefixBytes) cause = CauseShort;
      else if (size != len_field + LenOverhead && !cfg_ignore) cause = CauseLength;
      else cause = CauseNone;
      r = '0;
      r.item_kind    = KindVerdict;
      r.run_end      = 1'b1;
      r.accepted     = (cause == CauseNone);
      r.reject_cause = cause;
      r.length_value = len_field;
      r.code_first   = code_field[7:0];
      r.code_second  = code_field[15:8];
      r.custom_a     = custom_a_field;
      r.custom_b     = custom_b_field;
      expected_results = {expected_results, r};
      clear_packet();
    end
  endfunction

  function automatic byte_q_t build_packet(input int unsigned size, input logic [31:0] magic,
                                           input logic [15:0] len);
    byte_q_t q;
    for (int unsigned i = 0; i < size; i++) begin
      if (i < 4) q = {q, magic[8*i +: 8]};
      else if (i == 4) q = {q, len[7:0]};
      else if (i == 5) q = {q, len[15:8]};
      else q = {q, 8'($urandom_range(0, 255))};
    end
    return q;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      failed = 1'b1;
    end
  endtask

  // Valid stays high between back-to-back beats; it only drops for a gap.
  task automatic send_beat(input logic [7:0] data, input logic fin, input bit paced);
    int unsigned gap;
    gap = paced ? gap_length() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= data;
    in_ch.final_byte <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_beat(data, fin);
  endtask

  task automatic send_packet(input byte_q_t q, input bit typed, input cause_e cause);
    bit            paced;
    verdict_note_t note;
    paced = gaps_allowed && ($urandom_range(0, 3) != 0);
    note.typed = typed;
    note.cause = cause;
    verdict_notes = {verdict_notes, note};
    foreach (q[i]) send_beat(q[i], i == q.size() - 1, paced);
  endtask

  // Every packet ends in a verdict, so an empty store means the block is idle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_index_e idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CfgMagicWord: cfg_magic = value;
      CfgIgnoreLen: cfg_ignore = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] magic, input logic ignore_len);
    write_register(CfgMagicWord, magic);
    write_register(CfgIgnoreLen, {31'b0, ignore_len});
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [31:0] magic, input logic ignore_len,
                                  input int unsigned byte_budget);
    int unsigned sent_bytes;
    int unsigned roll;
    int unsigned size;
    int unsigned pos;
    logic [31:0] sent_magic;
    logic [15:0] len;
    byte_q_t     q;
    drain_results();
    configure(magic, ignore_len);
    sent_bytes = 0;
    while (sent_bytes < byte_budget) begin
      roll = $urandom_range(0, 99);
      size = 12 + (($urandom_range(0, 9) == 0) ? $urandom_range(21, 60) : $urandom_range(0, 20));
      len = 16'(size - 6);
      sent_magic = cfg_magic;
      if (roll < 70) begin
        // Well-formed packet with random content.
      end else if (roll < 78) begin
        pos = $urandom_range(0, 3);
        sent_magic[8*pos +: 8] = sent_magic[8*pos +: 8] ^ 8'($urandom_range(1, 255));
      end else if (roll < 86) begin
        size = $urandom_range(1, 11);
      end else if (roll < 94) begin
        if ($urandom_range(0, 1) != 0) len = 16'($urandom);
        else if ($urandom_range(0, 1) != 0) len = len + 1'b1;
        else len = len - 1'b1;
      end else begin
        size = $urandom_range(1, 40);
        sent_magic = $urandom;
        len = 16'($urandom);
      end
      q = build_packet(size, sent_magic, len);
      send_packet(q, 1'b0, CauseNone);
      sent_bytes += size;
    end
  endtask

  // Output side: ready windows of random length with stalls in between.
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ch.ready && stalls_on) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= gap_length();
    end else begin
      out_ch.ready <= 1'b1;
      ready_hold   <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 12);
    end
  end

  always @(posedge clk_i) begin
    result_t       want;
    verdict_note_t note;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no result expected");
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        compare_field("item_kind", want.item_kind, out_ch.item_kind);
        compare_field("payload_value", want.payload_value, out_ch.payload_value);
        compare_field("run_end", want.run_end, out_ch.run_end);
        compare_field("accepted", want.accepted, out_ch.accepted);
        compare_field("reject_cause", want.reject_cause, out_ch.reject_cause);
        compare_field("length_value", want.length_value, out_ch.length_value);
        compare_field("code_first", want.code_first, out_ch.code_first);
        compare_field("code_second", want.code_second, out_ch.code_second);
        compare_field("custom_a", want.custom_a, out_ch.custom_a);
        compare_field("custom_b", want.custom_b, out_ch.custom_b);
        if (want.item_kind == KindVerdict && verdict_notes.size() != 0) begin
          note = verdict_notes.pop_front();
          if (note.typed) begin
            compare_field("reject_cause (table)", note.cause, out_ch.reject_cause);
            compare_field("accepted (table)", note.cause == CauseNone, out_ch.accepted);
          end
        end
      end
    end
  end

  initial begin
    byte_q_t q;
    failed           = 1'b0;
    gaps_allowed     = 1'b1;
    stalls_on        = 1'b1;
    ready_hold       = 0;
    cfg_magic        = '0;
    cfg_ignore       = 1'b0;
    clear_packet();
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CfgMagicWord;
    cfg_ch.data      = '0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.final_byte = 1'b0;
    out_ch.ready     = 1'b0;
    rst_ni           = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first row runs on the reset values of the registers.
    foreach (directed_cases[i]) begin
      if (directed_cases[i].magic != cfg_magic || directed_cases[i].ignore_len != cfg_ignore)
      begin
        drain_results();
        configure(directed_cases[i].magic, directed_cases[i].ignore_len);
      end
      q = build_packet(directed_cases[i].size, directed_cases[i].sent_magic,
                       directed_cases[i].len_field);
      send_packet(q, directed_cases[i].typed, directed_cases[i].cause);
    end

    run_random_phase($urandom, 1'b0, 210);
    run_random_phase(32'h0000_0000, 1'b1, 210);
    run_random_phase(32'hFFFF_FFFF, 1'b0, 210);
    run_random_phase($urandom, 1'b1, 210);
    run_random_phase($urandom, 1'b0, 210);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+hdl
hdl/phd_pkg.sv
hdl/phd_if.sv
hdl/phd_cfg_regs.sv
hdl/phd_core.sv
hdl/phd_result_fifo.sv
hdl/packet_header_deframer.sv
tb/sv/packet_header_deframer_tb.sv
